// ===== hw/rtl/irsp_pkg.sv =====
// Package for the interlocked relay switch panel.
// Holds the beat widths, press code, reset values and mode codes.
// No dependencies.
package irsp_pkg;

  // Beat layout
  localparam int unsigned NUM_BYTES  = 11;
  localparam int unsigned IN_BITS    = NUM_BYTES * 8;
  localparam int unsigned NUM_LAMPS  = 10;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned NUM_TIMERS = 6;

  // Command kinds carried in tuser
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // A byte is a press only when it is ASCII '1'
  localparam logic [7:0] PRESS_CODE = 8'd49;

  localparam logic [CFG_BITS-1:0] LOCKOUT_RESET = 16'd50;

  // Mode machine codes; the unused code behaves as boost
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BOOST = 2'd2;

  // Mode lamp patterns on lamps 9-10
  localparam logic [1:0] MLAMP_IDLE  = 2'b00;
  localparam logic [1:0] MLAMP_ON    = 2'b01;
  localparam logic [1:0] MLAMP_BOOST = 2'b11;

  // Lockout timer slots
  localparam int unsigned TMR_LAMP5 = 0;
  localparam int unsigned TMR_LAMP6 = 1;
  localparam int unsigned TMR_LAMP7 = 2;
  localparam int unsigned TMR_LAMP8 = 3;
  localparam int unsigned TMR_ON    = 4;
  localparam int unsigned TMR_BOOST = 5;

endpackage

// ===== hw/rtl/interlocked_relay_switch_panel.sv =====
// Interlocked relay switch panel: top level.
// Frame and tick decode, lamp interlocks, mode machine and lockout timers.
// Depends on irsp_pkg.

// Every input beat is either an 11-byte button frame (tuser = 0) or a 10 ms
// tick (tuser = 1), and every beat yields exactly one output beat with the
// current ten lamp states and the activity lamp. The whole update runs as
// one pass of shallow logic from the panel state into the output register,
// so a new beat is taken every cycle while the output side keeps up; the
// single output register sets a one-beat depth between the two sides. The
// lockout reload value is written through the cfg channel, which is always
// ready, and should change only while the panel is idle.
module interlocked_relay_switch_panel
  import irsp_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // Input beats
  input  logic                s_tvalid,
  output logic                s_tready,
  // press_byte_1 [7:0], press_byte_2 [15:8], ... press_byte_11 [87:80]
  input  logic [IN_BITS-1:0]  s_tdata,
  // command [0]: 0 = button frame, 1 = tick
  input  logic                s_tuser,
  // Output beats
  output logic                m_tvalid,
  input  logic                m_tready,
  // lamps [9:0], activity_lamp [10], zero [15:11]
  output logic [OUT_BITS-1:0] m_tdata,
  // Lockout reload register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  // Panel state
  logic [CFG_BITS-1:0]   lockout_ticks;
  logic [3:0]            mom_lamps;
  logic [3:0]            mom_locks;
  logic [3:0]            tog_lamps;
  logic [1:0]            mode;
  logic [TIMER_BITS-1:0] timers [NUM_TIMERS];
  logic                  activity;

  logic [3:0]            mom_lamps_next;
  logic [3:0]            mom_locks_next;
  logic [3:0]            tog_lamps_next;
  logic [1:0]            mode_next;
  logic [TIMER_BITS-1:0] timers_next [NUM_TIMERS];
  logic                  activity_next;
  logic [1:0]            mode_lamps;

  logic [NUM_BYTES-1:0]  press;
  logic                  any_byte;
  logic [TIMER_BITS-1:0] reload;
  logic                  in_beat;

  // Momentary pair: returns {locks, lamps} for one pair, first button bit 0
  function automatic logic [3:0] mom_pair(input logic [1:0] lamp_in,
                                          input logic [1:0] lock_in,
                                          input logic       pa,
                                          input logic       pb);
    logic [1:0] l;
    logic [1:0] k;
    l = lamp_in;
    k = lock_in;
    if (!pa) begin
      l[0] = 1'b0;
      k[1] = 1'b0;
    end
    if (!pb) begin
      l[1] = 1'b0;
      k[0] = 1'b0;
    end
    if (pa && !k[0]) begin
      l[0] = 1'b1;
      k[1] = 1'b1;
    end
    if (pb && !k[1]) begin
      l[1] = 1'b1;
      k[0] = 1'b1;
    end
    return {k, l};
  endfunction

  // Toggle press: bit 0 is the pressed lamp, bit 1 its partner
  function automatic logic [1:0] tog_step(input logic [1:0] pair_in);
    logic [1:0] p;
    p = pair_in;
    if (!p[0]) begin
      if (!p[1]) begin
        p[0] = 1'b1;
      end
      p[1] = 1'b0;
    end else begin
      p[0] = 1'b0;
    end
    return p;
  endfunction

  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign reload    = TIMER_BITS'(lockout_ticks);

  // Decode the frame bytes
  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      press[i] = (s_tdata[i*8 +: 8] == PRESS_CODE);
    end
    any_byte = |s_tdata;
  end

  // Next panel state for the beat on the input
  always_comb begin
    logic [3:0] ma;
    logic [3:0] mb;
    logic [1:0] pr;
    ma             = '0;
    mb             = '0;
    pr             = '0;
    mom_lamps_next = mom_lamps;
    mom_locks_next = mom_locks;
    tog_lamps_next = tog_lamps;
    mode_next      = mode;
    activity_next  = activity;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      timers_next[t] = timers[t];
    end

    if (s_tuser == CMD_TICK) begin
      // Count lockouts down, hold at zero
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (timers[t] != '0) begin
          timers_next[t] = timers[t] - 1'b1;
        end
      end
    end else begin
      activity_next = any_byte;

      // Momentary pairs
      ma = mom_pair(mom_lamps[1:0], mom_locks[1:0], press[0], press[1]);
      mb = mom_pair(mom_lamps[3:2], mom_locks[3:2], press[2], press[3]);
      mom_lamps_next = {mb[1:0], ma[1:0]};
      mom_locks_next = {mb[3:2], ma[3:2]};

      // Toggle pairs, first button before second
      if (press[4] && timers[TMR_LAMP5] == '0) begin
        tog_lamps_next[1:0] = tog_step(tog_lamps_next[1:0]);
        timers_next[TMR_LAMP5] = reload;
      end
      if (press[5] && timers[TMR_LAMP6] == '0) begin
        pr = tog_step({tog_lamps_next[0], tog_lamps_next[1]});
        tog_lamps_next[1:0] = {pr[0], pr[1]};
        timers_next[TMR_LAMP6] = reload;
      end
      if (press[6] && timers[TMR_LAMP7] == '0) begin
        tog_lamps_next[3:2] = tog_step(tog_lamps_next[3:2]);
        timers_next[TMR_LAMP7] = reload;
      end
      if (press[7] && timers[TMR_LAMP8] == '0) begin
        pr = tog_step({tog_lamps_next[2], tog_lamps_next[3]});
        tog_lamps_next[3:2] = {pr[0], pr[1]};
        timers_next[TMR_LAMP8] = reload;
      end

      // Mode machine, enabled by byte 9
      if (press[8]) begin
        if (press[9] && timers[TMR_ON] == '0) begin
          if (!press[10]) begin
            mode_next = (mode == MODE_ON) ? MODE_IDLE : MODE_ON;
          end
          timers_next[TMR_ON] = reload;
        end
        if (press[10] && timers[TMR_BOOST] == '0) begin
          if (!press[9]) begin
            mode_next = (mode_next >= MODE_BOOST) ? MODE_IDLE : MODE_BOOST;
          end
          timers_next[TMR_BOOST] = reload;
        end
      end
    end
  end

  // Mode lamps
  always_comb begin
    case (mode_next)
      MODE_IDLE: mode_lamps = MLAMP_IDLE;
      MODE_ON:   mode_lamps = MLAMP_ON;
      default:   mode_lamps = MLAMP_BOOST;
    endcase
  end

  // Take config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lockout_ticks <= cfg_data;
    end
  end

  // Advance panel state on each input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mom_lamps <= '0;
      mom_locks <= '0;
      tog_lamps <= '0;
      mode      <= MODE_IDLE;
      activity  <= 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        timers[t] <= TIMER_BITS'(LOCKOUT_RESET);
      end
    end else if (in_beat) begin
      mom_lamps <= mom_lamps_next;
      mom_locks <= mom_locks_next;
      tog_lamps <= tog_lamps_next;
      mode      <= mode_next;
      activity  <= activity_next;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        timers[t] <= timers_next[t];
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {(OUT_BITS - NUM_LAMPS - 1)'(0), activity_next, mode_lamps,
                  tog_lamps_next, mom_lamps_next};
    end
  end

endmodule
